// ===== src/drs_pkg.sv =====
// Package for the disc read request sequencer.
// Holds the shared types, codes and constants; no dependencies.
package drs_pkg;

  localparam int QUEUE_DEPTH = 16;

  localparam int POS_W = 32;
  localparam int BYTES_W = 30;
  localparam int BUF_W = 32;
  localparam int SECT_W = 20;
  localparam int SECTOR_SHIFT = 11;
  localparam logic [BYTES_W:0] SECTOR_ROUND = 31'd2047;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_SEEK = 2'd2;

  localparam logic [1:0] DSTAT_COMPLETE = 2'd1;
  localparam logic [1:0] DSTAT_ERROR = 2'd2;

  localparam logic [1:0] RPROG_DONE = 2'd0;
  localparam logic [1:0] RPROG_ERROR = 2'd2;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_NOP    = 2'd1,
    CMD_SETLOC = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_ENQ_READ = 2'd1,
    KIND_ENQ_SEEK = 2'd2,
    KIND_IGNORE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STEP_IDLE        = 3'd0,
    STEP_NOP         = 3'd1,
    STEP_NOP_WAIT    = 3'd2,
    STEP_SETLOC      = 3'd3,
    STEP_SETLOC_WAIT = 3'd4,
    STEP_READ        = 3'd5,
    STEP_READ_WAIT   = 3'd6
  } step_t;

  typedef enum logic {
    PHASE_FETCH = 1'b0,
    PHASE_EXEC  = 1'b1
  } phase_t;

  typedef struct packed {
    kind_t              kind;
    logic [POS_W-1:0]   position;
    logic [SECT_W-1:0]  sectors;
    logic [BUF_W-1:0]   buffer;
    logic [1:0]         drive_status;
    logic               read_start_ok;
    logic [1:0]         read_progress;
  } work_t;

  typedef struct packed {
    logic               is_seek;
    logic [POS_W-1:0]   position;
    logic [SECT_W-1:0]  sectors;
    logic [BUF_W-1:0]   buffer;
  } entry_t;

endpackage

// ===== src/drs_if.sv =====
// Channel interfaces for the disc read request sequencer.
// Depends on drs_pkg for the field widths.
interface drs_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [drs_pkg::POS_W-1:0]     start_position;
  logic [drs_pkg::BYTES_W-1:0]   file_bytes;
  logic [drs_pkg::BUF_W-1:0]     buffer_address;
  logic [1:0]                    drive_status;
  logic                          read_start_ok;
  logic [1:0]                    read_progress;

  modport source (
    output valid, mode, start_position, file_bytes, buffer_address,
           drive_status, read_start_ok, read_progress,
    input  ready
  );
  modport sink (
    input  valid, mode, start_position, file_bytes, buffer_address,
           drive_status, read_start_ok, read_progress,
    output ready
  );
endinterface

interface drs_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [drs_pkg::POS_W-1:0]     command_position;
  logic [drs_pkg::SECT_W-1:0]    command_sectors;
  logic [drs_pkg::BUF_W-1:0]     command_buffer;
  logic                          accepted;
  logic                          retired;
  logic                          busy_res;

  modport source (
    output valid, command, command_position, command_sectors, command_buffer,
           accepted, retired, busy_res,
    input  ready
  );
  modport sink (
    input  valid, command, command_position, command_sectors, command_buffer,
           accepted, retired, busy_res,
    output ready
  );
endinterface

// ===== src/disc_read_request_sequencer.sv =====
// Disc read request sequencer: one result word for every input word.
// A word accepted into the queue is popped by the back end in its fetch phase, which also reads
// the head entry from the store; it is executed once the result register is free, and its result is registered.
// The back end alternates fetch and execute, so it takes no new word until the last one is executed.
// Reset clears the sequencer, the ring pointers and the entry valid bits; entries are not swept.
module disc_read_request_sequencer #(
  parameter int QUEUE_DEPTH = drs_pkg::QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  drs_in_if.sink     req,
  drs_out_if.source  rsp
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  logic             push;
  logic             push_ready;
  drs_pkg::work_t   push_data;
  logic             q_pop;
  logic             q_valid;
  drs_pkg::work_t   q_data;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  drs_pkg::entry_t  ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  drs_pkg::entry_t  ram_rdata;

  drs_front u_front (
    .req        (req),
    .push_ready (push_ready),
    .push       (push),
    .work       (push_data)
  );

  drs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  drs_ram #(
    .WIDTH ($bits(drs_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  drs_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .rsp       (rsp)
  );

endmodule

// ===== src/drs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module drs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/drs_front.sv =====
// Front end: accepts input words, classifies them and rounds bytes to sectors.
// Depends on drs_pkg and drs_in_if.
module drs_front (
  drs_in_if.sink          req,
  input  logic            push_ready,
  output logic            push,
  output drs_pkg::work_t  work
);

  logic [drs_pkg::BYTES_W:0] rounded;

  assign req.ready = push_ready;
  assign push = req.valid && push_ready;
  assign rounded = {1'b0, req.file_bytes} + drs_pkg::SECTOR_ROUND;

  always_comb begin
    unique case (req.mode)
      drs_pkg::MODE_TICK: work.kind = drs_pkg::KIND_TICK;
      drs_pkg::MODE_READ: work.kind = drs_pkg::KIND_ENQ_READ;
      drs_pkg::MODE_SEEK: work.kind = drs_pkg::KIND_ENQ_SEEK;
      default:            work.kind = drs_pkg::KIND_IGNORE;
    endcase
  end

  assign work.position = req.start_position;
  assign work.sectors = rounded[drs_pkg::BYTES_W:drs_pkg::SECTOR_SHIFT];
  assign work.buffer = req.buffer_address;
  assign work.drive_status = req.drive_status;
  assign work.read_start_ok = req.read_start_ok;
  assign work.read_progress = req.read_progress;

endmodule

// ===== src/drs_queue.sv =====
// Two-entry queue of classified words between the front and back ends.
// Depends on drs_pkg.
module drs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  drs_pkg::work_t  push_data,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output drs_pkg::work_t  pop_data
);

  drs_pkg::work_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign push_ready = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== src/drs_back.sv =====
// Back end: request ring control, seven-step drive sequencer and result register.
// Depends on drs_pkg, drs_out_if and the entry store held in drs_ram.
module drs_back #(
  parameter int QUEUE_DEPTH = drs_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  drs_pkg::work_t                 q_data,
  output logic                           q_pop,
  output logic                           ram_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_waddr,
  output drs_pkg::entry_t                ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_raddr,
  input  drs_pkg::entry_t                ram_rdata,
  drs_out_if.source                      rsp
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  drs_pkg::phase_t         phase;
  drs_pkg::phase_t         phase_next;
  drs_pkg::step_t          step;
  drs_pkg::step_t          step_next;
  logic [IDX_W-1:0]        head;
  logic [IDX_W-1:0]        head_next;
  logic [IDX_W-1:0]        tail;
  logic [IDX_W-1:0]        tail_next;
  logic [QUEUE_DEPTH-1:0]  entry_valid;
  logic [QUEUE_DEPTH-1:0]  entry_valid_next;
  drs_pkg::work_t          item;
  logic                    out_valid;
  logic                    exec;
  logic                    acc;
  logic                    ret;
  drs_pkg::cmd_t           cmd;
  logic [drs_pkg::POS_W-1:0]  cpos;
  logic [drs_pkg::SECT_W-1:0] csec;
  logic [drs_pkg::BUF_W-1:0]  cbuf;
  logic [IDX_W-1:0]        head_inc;
  logic [IDX_W-1:0]        tail_inc;

  assign head_inc = (head == LAST_IDX) ? '0 : head + IDX_W'(1);
  assign tail_inc = (tail == LAST_IDX) ? '0 : tail + IDX_W'(1);

  assign exec = (phase == drs_pkg::PHASE_EXEC) && (!out_valid || rsp.ready);
  assign q_pop = (phase == drs_pkg::PHASE_FETCH) && q_valid;
  assign ram_re = q_pop;
  assign ram_raddr = head;
  assign ram_waddr = tail;
  assign ram_wdata.is_seek = (item.kind == drs_pkg::KIND_ENQ_SEEK);
  assign ram_wdata.position = item.position;
  assign ram_wdata.sectors = item.sectors;
  assign ram_wdata.buffer = item.buffer;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      drs_pkg::PHASE_FETCH: if (q_valid) phase_next = drs_pkg::PHASE_EXEC;
      drs_pkg::PHASE_EXEC:  if (exec) phase_next = drs_pkg::PHASE_FETCH;
      default:              phase_next = drs_pkg::PHASE_FETCH;
    endcase
  end

  // Sequencer next state and ring bookkeeping.
  always_comb begin
    step_next = step;
    head_next = head;
    tail_next = tail;
    entry_valid_next = entry_valid;
    ram_we = 1'b0;
    acc = 1'b0;
    ret = 1'b0;
    case (item.kind) inside
      drs_pkg::KIND_ENQ_READ, drs_pkg::KIND_ENQ_SEEK: begin
        if (!entry_valid[tail]) begin
          ram_we = exec;
          entry_valid_next[tail] = 1'b1;
          step_next = drs_pkg::STEP_NOP;
          tail_next = tail_inc;
          acc = 1'b1;
        end
      end
      drs_pkg::KIND_TICK: begin
        unique case (step)
          drs_pkg::STEP_NOP: step_next = drs_pkg::STEP_NOP_WAIT;
          drs_pkg::STEP_NOP_WAIT: begin
            if (item.drive_status == drs_pkg::DSTAT_COMPLETE) begin
              step_next = drs_pkg::STEP_SETLOC;
            end else if (item.drive_status == drs_pkg::DSTAT_ERROR) begin
              step_next = drs_pkg::STEP_NOP;
            end
          end
          drs_pkg::STEP_SETLOC: step_next = drs_pkg::STEP_SETLOC_WAIT;
          drs_pkg::STEP_SETLOC_WAIT: begin
            if (item.drive_status == drs_pkg::DSTAT_COMPLETE) begin
              if (ram_rdata.is_seek) begin
                ret = 1'b1;
              end else begin
                step_next = drs_pkg::STEP_READ;
              end
            end else if (item.drive_status == drs_pkg::DSTAT_ERROR) begin
              step_next = drs_pkg::STEP_NOP;
            end
          end
          drs_pkg::STEP_READ: begin
            step_next = item.read_start_ok ? drs_pkg::STEP_READ_WAIT : drs_pkg::STEP_NOP;
          end
          drs_pkg::STEP_READ_WAIT: begin
            if (item.read_progress == drs_pkg::RPROG_DONE) begin
              ret = 1'b1;
            end else if (item.read_progress == drs_pkg::RPROG_ERROR) begin
              step_next = drs_pkg::STEP_NOP;
            end
          end
          default: step_next = step;
        endcase
        if (ret) begin
          entry_valid_next[head] = 1'b0;
          head_next = head_inc;
          step_next = entry_valid[head_inc] ? drs_pkg::STEP_NOP : drs_pkg::STEP_IDLE;
        end
      end
      default: step_next = step;
    endcase
  end

  // Command issued by the current step.
  always_comb begin
    cmd = drs_pkg::CMD_NONE;
    cpos = '0;
    csec = '0;
    cbuf = '0;
    if (item.kind == drs_pkg::KIND_TICK) begin
      unique case (step)
        drs_pkg::STEP_NOP: cmd = drs_pkg::CMD_NOP;
        drs_pkg::STEP_SETLOC: begin
          cmd = drs_pkg::CMD_SETLOC;
          cpos = ram_rdata.position;
        end
        drs_pkg::STEP_READ: begin
          cmd = drs_pkg::CMD_READ;
          csec = ram_rdata.sectors;
          cbuf = ram_rdata.buffer;
        end
        default: cmd = drs_pkg::CMD_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= drs_pkg::PHASE_FETCH;
      step <= drs_pkg::STEP_IDLE;
      head <= '0;
      tail <= '0;
      entry_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (exec) begin
        step <= step_next;
        head <= head_next;
        tail <= tail_next;
        entry_valid <= entry_valid_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_data;
    end
    if (exec) begin
      rsp.command <= cmd;
      rsp.command_position <= cpos;
      rsp.command_sectors <= csec;
      rsp.command_buffer <= cbuf;
      rsp.accepted <= acc;
      rsp.retired <= ret;
      rsp.busy_res <= (step_next != drs_pkg::STEP_IDLE);
    end
  end

  assign rsp.valid = out_valid;

endmodule
